@@ hw/rtl/touch_stop_race_timer_core_defines.svh @@
// assertion macros for the checker file
`ifndef TOUCH_STOP_RACE_TIMER_CORE_DEFINES_SVH
`define TOUCH_STOP_RACE_TIMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TRST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("touch stop timer check failed");

// next-cycle implication, sampled on clk, off while in reset
`define TRST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("touch stop timer check failed");

`endif

@@ hw/rtl/trst_pkg.sv @@
// types and constants of the touch stop race timer
`default_nettype none

package trst_pkg;

	typedef enum logic [1:0] {
		MODE_STOP      = 2'd0,
		MODE_COUNTDOWN = 2'd1,
		MODE_TIMING    = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CFG_TOUCH_THRESHOLD   = 2'd0,
		CFG_COUNTDOWN_SECONDS = 2'd1,
		CFG_POLL_INTERVAL_MS  = 2'd2,
		CFG_TICKS_PER_SECOND  = 2'd3
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] RST_TOUCH_THRESHOLD   = 16'd10000;
	localparam logic [3:0]  RST_COUNTDOWN_SECONDS = 4'd5;
	localparam logic [7:0]  RST_POLL_INTERVAL_MS  = 8'd10;
	localparam logic [15:0] RST_TICKS_PER_SECOND  = 16'd1000;

	localparam logic [3:0] DIGIT_MAX   = 4'd9;
	localparam logic [5:0] SECONDS_MAX = 6'd59;
	localparam logic [6:0] MINUTES_MAX = 7'd99;

	typedef struct packed {
		logic        ms_tick;
		logic [15:0] touch_sample;
		logic        start_switch_level;
		logic        clear_switch_level;
	} poll_item_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  countdown_digit;
		logic        go_shown;
		logic [3:0]  millis_digit;
		logic [3:0]  tens_ms_digit;
		logic [3:0]  hundreds_ms_digit;
		logic [5:0]  seconds_count;
		logic [6:0]  minutes_count;
		logic [7:0]  event_count;
		logic        touch_stopped;
	} result_item_t;

	typedef struct packed {
		logic [3:0] ms;
		logic [3:0] tms;
		logic [3:0] hms;
		logic [5:0] secs;
		logic [6:0] mins;
	} elapsed_t;

	// verified presses from the switch debouncer
	typedef struct packed {
		logic start_verified;
		logic clear_verified;
	} press_evt_t;

endpackage

`default_nettype wire

@@ hw/rtl/touch_stop_race_timer_core.sv @@
// top level of the touch stop race timer
// one poll item in, one result item out. an accepted item lands in an input register;
// once the output register is free, the stopwatch state is updated from it and the result is
// written to an output register; a new item is taken every cycle while the result side keeps
// up, so the sustained rate is one item per clock, and result valid comes from the output
// register. ready on the poll side follows result_ready through the two registers. the
// registers are written through cfg_we / cfg_index / cfg_data and should change only while
// no item is in flight. the result shows the state after its item: mode, countdown digit,
// go and touch strobes, elapsed digits and the stop event count
`default_nettype none

module touch_stop_race_timer_core
	import trst_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// poll items
	input  wire logic                  poll_valid,
	output logic                       poll_ready,
	input  wire poll_item_t            poll,
	// result items
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_item_t               result,
	// register writes
	input  wire logic                  cfg_we,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [15:0] touch_threshold_q;
	logic [3:0]  countdown_seconds_q;
	logic [7:0]  poll_interval_ms_q;
	logic [15:0] ticks_per_second_q;

	// input stage
	logic       valid_s1;
	poll_item_t item_s1;

	// output stage
	logic         result_valid_q;
	result_item_t result_q;

	// stopwatch state
	mode_t       mode_q;
	logic [15:0] baseline_q;
	logic        pending_q;
	logic [7:0]  events_q;
	logic [7:0]  poll_cnt_q;
	logic [15:0] cd_ticks_q;
	logic [4:0]  cd_remain_q;

	// next state and strobes
	mode_t       mode_d;
	logic [15:0] baseline_d;
	logic        pending_d;
	logic [7:0]  events_d;
	logic [7:0]  poll_cnt_d;
	logic [15:0] cd_ticks_d;
	logic [4:0]  cd_remain_d;
	logic [3:0]  digit;
	logic        go;
	logic        touched;

	logic        advance_s1;
	logic        fire;
	logic        start_pressed;
	logic        clear_pressed;
	logic [7:0]  interval;
	logic [7:0]  poll_cnt_inc;
	logic        poll_hit;
	logic [15:0] tps;
	logic [15:0] cd_ticks_inc;
	logic        sec_hit;
	logic        capture;
	logic        timing_test;
	logic [16:0] upper_bound;
	logic [16:0] sample_plus;
	press_evt_t  press;
	elapsed_t    elapsed_d;

	// handshake: the output register frees the input register, which frees the port
	assign advance_s1   = ~result_valid_q | result_ready;
	assign fire         = valid_s1 & advance_s1;
	assign poll_ready   = ~valid_s1 | advance_s1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// switches are active low
	assign start_pressed = ~item_s1.start_switch_level;
	assign clear_pressed = ~item_s1.clear_switch_level;

	// stop mode: debounce poll every interval ticks, a zero interval acts as one
	assign interval     = (poll_interval_ms_q == '0) ? 8'd1 : poll_interval_ms_q;
	assign poll_cnt_inc = poll_cnt_q + 8'd1;
	assign poll_hit     = (mode_q == MODE_STOP) & item_s1.ms_tick & (poll_cnt_inc >= interval);

	// countdown: one second is tps ticks, zero acts as one
	assign tps          = (ticks_per_second_q == '0) ? 16'd1 : ticks_per_second_q;
	assign cd_ticks_inc = cd_ticks_q + 16'd1;
	assign sec_hit      = (mode_q == MODE_COUNTDOWN) & item_s1.ms_tick & (cd_ticks_inc >= tps);

	// timing: the first item captures the baseline, the rest are tested for a touch
	assign capture     = (mode_q == MODE_TIMING) & pending_q;
	assign timing_test = (mode_q == MODE_TIMING) & ~pending_q;
	assign upper_bound = {1'b0, baseline_q} + {1'b0, touch_threshold_q};
	assign sample_plus = {1'b0, item_s1.touch_sample} + {1'b0, touch_threshold_q};
	assign touched     = timing_test &
		(({1'b0, item_s1.touch_sample} > upper_bound) | (sample_plus < {1'b0, baseline_q}));

	trst_debounce u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.poll_en       (fire & poll_hit),
		.start_pressed (start_pressed),
		.clear_pressed (clear_pressed),
		.evt           (press)
	);

	trst_elapsed u_elapsed (
		.clk       (clk),
		.arst_n    (arst_n),
		.update_en (fire),
		.clear     (capture),
		.advance   (timing_test & item_s1.ms_tick),
		.digits_d  (elapsed_d)
	);

	always_comb begin
		mode_d      = mode_q;
		baseline_d  = baseline_q;
		pending_d   = pending_q;
		events_d    = events_q;
		poll_cnt_d  = poll_cnt_q;
		cd_ticks_d  = cd_ticks_q;
		cd_remain_d = cd_remain_q;
		go          = 1'b0;
		digit       = '0;
		unique case (mode_q)
			MODE_STOP: begin
				if (item_s1.ms_tick) poll_cnt_d = poll_hit ? 8'd0 : poll_cnt_inc;
				if (press.start_verified) begin
					mode_d      = MODE_COUNTDOWN;
					cd_ticks_d  = '0;
					cd_remain_d = {1'b0, countdown_seconds_q} + 5'd1;
				end
				if (press.clear_verified) events_d = '0;
			end
			MODE_COUNTDOWN: begin
				if (item_s1.ms_tick) cd_ticks_d = sec_hit ? 16'd0 : cd_ticks_inc;
				if (sec_hit) begin
					if (cd_remain_q != '0) cd_remain_d = cd_remain_q - 5'd1;
					if (cd_remain_d == '0) begin
						mode_d    = MODE_TIMING;
						pending_d = 1'b1;
						go        = 1'b1;
					end
				end
				// blank while remaining exceeds the configured digits
				if (!go && (cd_remain_d <= {1'b0, countdown_seconds_q}))
					digit = cd_remain_d[3:0];
			end
			MODE_TIMING: begin
				if (capture) begin
					baseline_d = item_s1.touch_sample;
					pending_d  = 1'b0;
				end else if (touched) begin
					mode_d     = MODE_STOP;
					poll_cnt_d = '0;
					events_d   = events_q + 8'd1;
				end
			end
			default: begin
				mode_d     = MODE_STOP;
				poll_cnt_d = '0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_threshold_q   <= RST_TOUCH_THRESHOLD;
			countdown_seconds_q <= RST_COUNTDOWN_SECONDS;
			poll_interval_ms_q  <= RST_POLL_INTERVAL_MS;
			ticks_per_second_q  <= RST_TICKS_PER_SECOND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOUCH_THRESHOLD:   touch_threshold_q   <= cfg_data[15:0];
				CFG_COUNTDOWN_SECONDS: countdown_seconds_q <= cfg_data[3:0];
				CFG_POLL_INTERVAL_MS:  poll_interval_ms_q  <= cfg_data[7:0];
				CFG_TICKS_PER_SECOND:  ticks_per_second_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ready && poll_valid) item_s1 <= poll;
	end

	// stopwatch state, advanced once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOP;
			baseline_q  <= '0;
			pending_q   <= 1'b0;
			events_q    <= '0;
			poll_cnt_q  <= '0;
			cd_ticks_q  <= '0;
			cd_remain_q <= '0;
		end else if (fire) begin
			mode_q      <= mode_d;
			baseline_q  <= baseline_d;
			pending_q   <= pending_d;
			events_q    <= events_d;
			poll_cnt_q  <= poll_cnt_d;
			cd_ticks_q  <= cd_ticks_d;
			cd_remain_q <= cd_remain_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance_s1) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.mode              <= mode_d;
			result_q.countdown_digit   <= digit;
			result_q.go_shown          <= go;
			result_q.millis_digit      <= elapsed_d.ms;
			result_q.tens_ms_digit     <= elapsed_d.tms;
			result_q.hundreds_ms_digit <= elapsed_d.hms;
			result_q.seconds_count     <= elapsed_d.secs;
			result_q.minutes_count     <= elapsed_d.mins;
			result_q.event_count       <= events_d;
			result_q.touch_stopped     <= touched;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/trst_debounce.sv @@
// two-poll debouncer for the start and clear switches
`default_nettype none

module trst_debounce
	import trst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       poll_en,
	input  wire logic       start_pressed,
	input  wire logic       clear_pressed,
	output press_evt_t      evt
);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_EDGE     = 2'd1,
		PH_VERIFIED = 2'd2
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   any_pressed;

	assign any_pressed = start_pressed | clear_pressed;

	always_comb begin
		phase_d            = phase_q;
		evt.start_verified = 1'b0;
		evt.clear_verified = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (any_pressed) phase_d = PH_EDGE;
			end
			PH_EDGE: begin
				if (any_pressed) begin
					phase_d            = PH_VERIFIED;
					evt.start_verified = poll_en & start_pressed;
					evt.clear_verified = poll_en & ~start_pressed;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_VERIFIED: begin
				// stays verified only while both are held
				if (!start_pressed || !clear_pressed) phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (poll_en) begin
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/trst_elapsed.sv @@
// decimal elapsed time counter: ms, tens, hundreds, seconds, minutes
`default_nettype none

module trst_elapsed
	import trst_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       update_en,
	input  wire logic       clear,
	input  wire logic       advance,
	output elapsed_t        digits_d
);

	elapsed_t digits_q;

	always_comb begin
		digits_d = digits_q;
		if (clear) begin
			digits_d = '0;
		end else if (advance) begin
			if (digits_q.ms < DIGIT_MAX) begin
				digits_d.ms = digits_q.ms + 4'd1;
			end else begin
				digits_d.ms = '0;
				if (digits_q.tms < DIGIT_MAX) begin
					digits_d.tms = digits_q.tms + 4'd1;
				end else begin
					digits_d.tms = '0;
					if (digits_q.hms < DIGIT_MAX) begin
						digits_d.hms = digits_q.hms + 4'd1;
					end else begin
						digits_d.hms = '0;
						if (digits_q.secs < SECONDS_MAX) begin
							digits_d.secs = digits_q.secs + 6'd1;
						end else begin
							digits_d.secs = '0;
							// minutes wrap at 100
							if (digits_q.mins < MINUTES_MAX)
								digits_d.mins = digits_q.mins + 7'd1;
							else
								digits_d.mins = '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
		end else if (update_en) begin
			digits_q <= digits_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/trst_checker.sv @@
// port-level checks of the touch stop race timer, bound to the top level
`default_nettype none

`include "touch_stop_race_timer_core_defines.svh"

module trst_checker
	import trst_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  poll_valid,
	input wire logic                  poll_ready,
	input wire poll_item_t            poll,
	input wire logic                  result_valid,
	input wire logic                  result_ready,
	input wire result_item_t          result,
	input wire logic                  cfg_we,
	input wire cfg_index_t            cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic result_stall;
	logic go_ok;
	logic stop_ok;
	logic digits_ok;

	assign result_stall = result_valid && !result_ready;
	assign go_ok        = (result.mode == MODE_TIMING) && (result.countdown_digit == '0);
	assign stop_ok      = (result.mode == MODE_STOP) && !result.go_shown;
	assign digits_ok    = (result.millis_digit <= DIGIT_MAX) &&
		(result.seconds_count <= SECONDS_MAX) && (result.minutes_count <= MINUTES_MAX);

	// a stalled result holds
	`TRST_ASSERT_NEXT(a_result_hold, result_stall, result_valid && $stable(result))

	// go lands in timing with a blank digit
	`TRST_ASSERT_NOW(a_go_timing, result_valid && result.go_shown, go_ok)

	// a touch stop leaves the block stopped
	`TRST_ASSERT_NOW(a_touch_stop, result_valid && result.touch_stopped, stop_ok)

	// the millisecond digit, seconds and minutes stay in range
	`TRST_ASSERT_NOW(a_digits_range, result_valid, digits_ok)

endmodule

bind touch_stop_race_timer_core trst_checker u_trst_checker (.*);

`default_nettype wire
